### rtl/stsr_pkg.sv
// ----------------------------------------------------------------------------
// stsr_pkg
// Shared types, constants and the seed table for the seeded range generator.
// ----------------------------------------------------------------------------
package stsr_pkg;

  localparam logic [31:0] MULT_CONST = 32'd69069;
  localparam int unsigned DRAW_W     = 28;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned N_DRAW     = 3;
  // input register + two stages per draw cell + one per remainder bit + output
  localparam int unsigned LATENCY    = 1 + 2 * N_DRAW + DRAW_W + 1;

  // Draw counts per mode
  localparam logic [1:0] DRAWS_INT  = 2'd1;
  localparam logic [1:0] DRAWS_FRAC = 2'd3;

  localparam logic FUNC_INT  = 1'b0;
  localparam logic FUNC_FRAC = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] lo;
    logic [32:0] span;   // high - low + 1, with a wrapped zero read as 2^32
  } ctl_t;

  localparam logic [14:0] SEED_TAB [0:255] = '{
    15'd28985, 15'd27138, 15'd26457, 15'd9451, 15'd17764, 15'd10909, 15'd28790, 15'd8716,
    15'd6361, 15'd4853, 15'd17798, 15'd21977, 15'd19643, 15'd20662, 15'd10834, 15'd20103,
    15'd27067, 15'd28634, 15'd18623, 15'd25849, 15'd8576, 15'd26234, 15'd23887, 15'd18228,
    15'd32587, 15'd4836, 15'd3306, 15'd1811, 15'd3035, 15'd24559, 15'd18399, 15'd315,
    15'd26766, 15'd907, 15'd24102, 15'd12370, 15'd9674, 15'd2972, 15'd10472, 15'd16492,
    15'd22683, 15'd11529, 15'd27968, 15'd30406, 15'd13213, 15'd2319, 15'd23620, 15'd16823,
    15'd10013, 15'd23772, 15'd21567, 15'd1251, 15'd19579, 15'd20313, 15'd18241, 15'd30130,
    15'd8402, 15'd20807, 15'd27354, 15'd7169, 15'd21211, 15'd17293, 15'd5410, 15'd19223,
    15'd10255, 15'd22480, 15'd27388, 15'd9946, 15'd15628, 15'd24389, 15'd17308, 15'd2370,
    15'd9530, 15'd31683, 15'd25927, 15'd23567, 15'd11694, 15'd26397, 15'd32602, 15'd15031,
    15'd18255, 15'd17582, 15'd1422, 15'd28835, 15'd23607, 15'd12597, 15'd20602, 15'd10138,
    15'd5212, 15'd1252, 15'd10074, 15'd23166, 15'd19823, 15'd31667, 15'd5902, 15'd24630,
    15'd18948, 15'd14330, 15'd14950, 15'd8939, 15'd23540, 15'd21311, 15'd22428, 15'd22391,
    15'd3583, 15'd29004, 15'd30498, 15'd18714, 15'd4278, 15'd2437, 15'd22430, 15'd3439,
    15'd28313, 15'd23161, 15'd25396, 15'd13471, 15'd19324, 15'd15287, 15'd2563, 15'd18901,
    15'd13103, 15'd16867, 15'd9714, 15'd14322, 15'd15197, 15'd26889, 15'd19372, 15'd26241,
    15'd31925, 15'd14640, 15'd11497, 15'd8941, 15'd10056, 15'd6451, 15'd28656, 15'd10737,
    15'd13874, 15'd17356, 15'd8281, 15'd25937, 15'd1661, 15'd4850, 15'd7448, 15'd12744,
    15'd21826, 15'd5477, 15'd10167, 15'd16705, 15'd26897, 15'd8839, 15'd30947, 15'd27978,
    15'd27283, 15'd24685, 15'd32298, 15'd3525, 15'd12398, 15'd28726, 15'd9475, 15'd10208,
    15'd617, 15'd13467, 15'd22287, 15'd2376, 15'd6097, 15'd26312, 15'd2974, 15'd9114,
    15'd21787, 15'd28010, 15'd4725, 15'd15387, 15'd3274, 15'd10762, 15'd31695, 15'd17320,
    15'd18324, 15'd12441, 15'd16801, 15'd27376, 15'd22464, 15'd7500, 15'd5666, 15'd18144,
    15'd15314, 15'd31914, 15'd31627, 15'd6495, 15'd5226, 15'd31203, 15'd2331, 15'd4668,
    15'd12650, 15'd18275, 15'd351, 15'd7268, 15'd31319, 15'd30119, 15'd7600, 15'd2905,
    15'd13826, 15'd11343, 15'd13053, 15'd15583, 15'd30055, 15'd31093, 15'd5067, 15'd761,
    15'd9685, 15'd11070, 15'd21369, 15'd27155, 15'd3663, 15'd26542, 15'd20169, 15'd12161,
    15'd15411, 15'd30401, 15'd7580, 15'd31784, 15'd8985, 15'd29367, 15'd20989, 15'd14203,
    15'd29694, 15'd21167, 15'd10337, 15'd1706, 15'd28578, 15'd887, 15'd3373, 15'd19477,
    15'd14382, 15'd675, 15'd7033, 15'd15111, 15'd26138, 15'd12252, 15'd30996, 15'd21409,
    15'd25678, 15'd18555, 15'd13256, 15'd23316, 15'd22407, 15'd16727, 15'd991, 15'd9236,
    15'd5373, 15'd29402, 15'd6117, 15'd15241, 15'd27715, 15'd19291, 15'd19888, 15'd19847
  };

  function automatic logic [31:0] tab_lookup(input logic [7:0] idx);
    tab_lookup = {17'd0, SEED_TAB[idx]};
  endfunction

endpackage

### rtl/stsr_draw_cell.sv
// ----------------------------------------------------------------------------
// stsr_draw_cell
// Generator step, two stages: multiply, then table add and +1 if draws remain.
// ----------------------------------------------------------------------------
module stsr_draw_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  stsr_pkg::ctl_t      ctl_i,
  input  logic [31:0]         word_i,
  input  logic [1:0]          cnt_i,
  output logic                vld_o,
  output stsr_pkg::ctl_t      ctl_o,
  output logic [31:0]         word_o,
  output logic [1:0]          cnt_o
);
  import stsr_pkg::*;

  logic        vld_a_r;
  ctl_t        ctl_a_r;
  logic [31:0] prod_r, word_a_r;
  logic [1:0]  cnt_a_r;

  logic        vld_b_r;
  ctl_t        ctl_b_r;
  logic [31:0] word_b_r, word_b_nxt;
  logic [1:0]  cnt_b_r, cnt_b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_i;
      vld_b_r <= vld_a_r;
    end
  end

  always_comb begin
    if (cnt_a_r != 2'd0) begin
      word_b_nxt = prod_r + tab_lookup(prod_r[7:0]) + 32'd1;
      cnt_b_nxt  = cnt_a_r - 2'd1;
    end else begin
      word_b_nxt = word_a_r;
      cnt_b_nxt  = cnt_a_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl_a_r  <= ctl_i;
    prod_r   <= word_i * MULT_CONST;
    word_a_r <= word_i;
    cnt_a_r  <= cnt_i;
    ctl_b_r  <= ctl_a_r;
    word_b_r <= word_b_nxt;
    cnt_b_r  <= cnt_b_nxt;
  end

  assign vld_o  = vld_b_r;
  assign ctl_o  = ctl_b_r;
  assign word_o = word_b_r;
  assign cnt_o  = cnt_b_r;
endmodule

### rtl/stsr_mod_cell.sv
// ----------------------------------------------------------------------------
// stsr_mod_cell
// One restoring remainder step: shifts in one draw bit, subtracts the span when it fits.
// ----------------------------------------------------------------------------
module stsr_mod_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vld_i,
  input  stsr_pkg::ctl_t                  ctl_i,
  input  logic [31:0]                     rem_i,
  input  logic [stsr_pkg::DRAW_W-1:0]     num_i,
  input  logic [stsr_pkg::FRAC_W-1:0]     frac_i,
  output logic                            vld_o,
  output stsr_pkg::ctl_t                  ctl_o,
  output logic [31:0]                     rem_o,
  output logic [stsr_pkg::DRAW_W-1:0]     num_o,
  output logic [stsr_pkg::FRAC_W-1:0]     frac_o
);
  import stsr_pkg::*;

  logic              vld_r;
  ctl_t              ctl_r;
  logic [31:0]       rem_r;
  logic [DRAW_W-1:0] num_r;
  logic [FRAC_W-1:0] frac_r;
  logic [32:0]       trial;
  logic [32:0]       rem_nxt;

  // remainder stays below span, so the difference always fits 32 bits
  always_comb begin
    trial = {rem_i, num_i[DRAW_W-1]};
    if (trial >= ctl_i.span) rem_nxt = trial - ctl_i.span;
    else                     rem_nxt = trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    ctl_r  <= ctl_i;
    rem_r  <= rem_nxt[31:0];
    num_r  <= {num_i[DRAW_W-2:0], 1'b0};
    frac_r <= frac_i;
  end

  assign vld_o  = vld_r;
  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign frac_o = frac_r;
endmodule

### rtl/seeded_table_random_range.sv
// ----------------------------------------------------------------------------
// seeded_table_random_range
// Seeded table generator giving a bounded integer or a 16-bit fraction.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is always low, every stage advances.
// The pipeline holds an input register, 3 draw cells of 2 stages, 28 one-bit remainder cells and an output register.
// Reset (synchronous, active low) clears the stage valid bits only.
// The receiver cannot stall: each result shows for one cycle with out_valid.
// ----------------------------------------------------------------------------
module seeded_table_random_range (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_start,
  output logic               busy,
  input  logic               in_func,
  input  logic [31:0]        in_seed,
  input  logic signed [31:0] in_low_bound,
  input  logic signed [31:0] in_high_bound,
  output logic               out_valid,
  output logic signed [31:0] out_value
);
  import stsr_pkg::*;

  // Input stage: span and the seed-table word
  logic        vld0_r;
  ctl_t        ctl0_r, ctl0_nxt;
  logic [31:0] word0_r, word0_nxt;
  logic [1:0]  cnt0_r, cnt0_nxt;
  logic [31:0] span32;
  logic [7:0]  seed_idx;

  assign busy = 1'b0;

  always_comb begin
    span32        = in_high_bound - in_low_bound + 32'd1;
    seed_idx      = in_seed[7:0] + in_low_bound[7:0] + in_high_bound[7:0];
    word0_nxt     = tab_lookup(seed_idx);
    ctl0_nxt.func = in_func;
    ctl0_nxt.lo   = in_low_bound;
    // a span wrapped to zero means 2^32; span of one gives remainder zero
    ctl0_nxt.span = {(span32 == 32'd0), span32};
    cnt0_nxt      = (in_func == FUNC_FRAC) ? DRAWS_FRAC : DRAWS_INT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else        vld0_r <= in_start && !busy;
  end

  always_ff @(posedge clk) begin
    ctl0_r  <= ctl0_nxt;
    word0_r <= word0_nxt;
    cnt0_r  <= cnt0_nxt;
  end

  // Draw chain: a cell steps the word only while draws remain
  logic        dv   [0:N_DRAW];
  ctl_t        dctl [0:N_DRAW];
  logic [31:0] dword[0:N_DRAW];
  logic [1:0]  dcnt [0:N_DRAW];

  assign dv[0]    = vld0_r;
  assign dctl[0]  = ctl0_r;
  assign dword[0] = word0_r;
  assign dcnt[0]  = cnt0_r;

  for (genvar i = 0; i < N_DRAW; i++) begin : g_draw
    stsr_draw_cell u_draw (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (dv[i]),
      .ctl_i  (dctl[i]),
      .word_i (dword[i]),
      .cnt_i  (dcnt[i]),
      .vld_o  (dv[i+1]),
      .ctl_o  (dctl[i+1]),
      .word_o (dword[i+1]),
      .cnt_o  (dcnt[i+1])
    );
  end

  // Remainder chain: one draw bit per cell, MSB first
  logic              mv   [0:DRAW_W];
  ctl_t              mctl [0:DRAW_W];
  logic [31:0]       mrem [0:DRAW_W];
  logic [DRAW_W-1:0] mnum [0:DRAW_W];
  logic [FRAC_W-1:0] mfrac[0:DRAW_W];

  assign mv[0]    = dv[N_DRAW];
  assign mctl[0]  = dctl[N_DRAW];
  assign mrem[0]  = 32'd0;
  assign mnum[0]  = dword[N_DRAW][DRAW_W-1:0];
  assign mfrac[0] = dword[N_DRAW][FRAC_W-1:0];

  for (genvar j = 0; j < DRAW_W; j++) begin : g_mod
    stsr_mod_cell u_mod (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (mv[j]),
      .ctl_i  (mctl[j]),
      .rem_i  (mrem[j]),
      .num_i  (mnum[j]),
      .frac_i (mfrac[j]),
      .vld_o  (mv[j+1]),
      .ctl_o  (mctl[j+1]),
      .rem_o  (mrem[j+1]),
      .num_o  (mnum[j+1]),
      .frac_o (mfrac[j+1])
    );
  end

  // Output register
  logic        out_valid_r;
  logic [31:0] out_value_r, out_value_nxt;

  always_comb begin
    if (mctl[DRAW_W].func == FUNC_FRAC)
      out_value_nxt = {{(32-FRAC_W){1'b0}}, mfrac[DRAW_W]};
    else
      out_value_nxt = mctl[DRAW_W].lo + mrem[DRAW_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= mv[DRAW_W];
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

`ifndef NO_ASSERTIONS
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_start, LATENCY))
    else $error("result without a request");

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_start && !busy |-> ##LATENCY out_valid)
    else $error("request lost");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_func, LATENCY) |-> out_value[31:16] == 16'd0)
    else $error("fraction above 16 bits");

  a_single_span: assert property (@(posedge clk) disable iff (!rst_n)
    in_start && !busy && in_func == FUNC_INT && in_high_bound == in_low_bound
      |-> ##LATENCY out_value == $past(in_low_bound, LATENCY))
    else $error("single-value span not returning low bound");
`endif
endmodule
